### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared checks for the enrollment table, sampled on clk_i
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is masked while rst_ni is low
`define CMET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that also holds during reset
`define CMET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/cmet_pkg.sv
// ----------------------------------------------------------------------------
// cmet_pkg
// sizes, widths and codes of the cosine match enrollment table
// ----------------------------------------------------------------------------
`default_nettype none

package cmet_pkg;

  localparam int MAX_ENTRIES = 10;
  localparam int EMBED_DIM   = 512;

  localparam int ELEM_W   = 16;
  localparam int LABEL_W  = 8;
  localparam int STATUS_W = 3;
  localparam int ECNT_W   = 4;

  localparam int SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = $clog2(EMBED_DIM + 1);
  localparam int EA_W    = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int STORE_DEPTH = MAX_ENTRIES * EMBED_DIM;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // sum of squares, signed dot product, square root of the sum
  localparam int NORM_W = 2 * ELEM_W + $clog2(EMBED_DIM + 1);
  localparam int DOT_W  = NORM_W + 1;
  localparam int SQ_W   = (NORM_W + 1) / 2;
  localparam int SQV_W  = 2 * SQ_W;
  localparam int DEN_W  = 2 * SQ_W;

  // quotient (|dot| * 2^16 + den) / (2 * den), saturated at 2^16
  localparam int SCALE_SH = ELEM_W;
  localparam int Q_W      = SCALE_SH + 1;
  localparam int NUM_W    = DEN_W + Q_W + 1;
  localparam int ITER_W   = $clog2((SQ_W > Q_W) ? SQ_W : Q_W);

  localparam logic signed [ELEM_W-1:0] SIM_MIN = -16'sd32768;
  localparam logic signed [ELEM_W-1:0] SIM_MAX = 16'sd32767;
  localparam logic signed [ELEM_W-1:0] THR_RESET = 16'sd19661;

  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_ENROLL     = 2'd1,
    OP_FORGET     = 2'd2,
    OP_FORGET_ALL = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_GATE      = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

endpackage

`default_nettype wire

### design/cosine_match_enrollment_table.sv
// ----------------------------------------------------------------------------
// cosine_match_enrollment_table
// ordered table of labeled embeddings with cosine nearest neighbor probe
// ----------------------------------------------------------------------------
// Enroll elements are written into the embedding memory as they arrive. For a
// probe element one shared 16x16 multiplier walks the enrolled entries through
// the single read port of the embedding memory. The last element of a stream
// adds a square root of the stream's sum of squares and, for a probe, a 17-step
// restoring divider per enrolled entry (skipped when a norm is zero or the
// quotient saturates) and a compare that keeps the best entry. The result is
// then loaded into the output register. Forget and forget-all reach entries
// through a slot map, so no embedding data moves. Each result sits in an output
// register, and the block waits there only when the previous result has not been
// taken.
`default_nettype none
`include "assert_macros.svh"

module cosine_match_enrollment_table
  import cmet_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [ELEM_W-1:0] element_i,
  input  logic                     last_i,
  input  logic [LABEL_W-1:0]       label_i,
  input  logic                     gate_ok_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [LABEL_W-1:0]       match_label_o,
  output logic                     matched_o,
  output logic signed [ELEM_W-1:0] similarity_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [ECNT_W-1:0]        entry_count_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [ELEM_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_SQI, S_SQRT, S_EFIN, S_DEN, S_DIV0, S_DIV, S_CMP, S_PFIN, S_OUT
  } state_e;

  state_e state_q;

  // table
  logic [CNT_W-1:0]         count_q;
  logic [SLOT_W-1:0]        map_q [MAX_ENTRIES];
  logic [LABEL_W-1:0]       lab_q [MAX_ENTRIES];
  logic [SQ_W-1:0]          sqn_q [MAX_ENTRIES];
  logic [IDX_W-1:0]         len_q [MAX_ENTRIES];
  logic signed [DOT_W-1:0]  dot_q [MAX_ENTRIES];
  logic signed [ELEM_W-1:0] thr_q;

  // stream
  logic [NORM_W-1:0]        norm_q;
  logic [IDX_W-1:0]         eidx_q;
  logic                     kind_q;
  logic                     last_q;
  logic [LABEL_W-1:0]       lab_in_q;
  logic                     gate_q;
  logic signed [ELEM_W-1:0] elem_q;
  logic [IDX_W-1:0]         midx_q;
  logic [CNT_W-1:0]         k_q;

  // multiply pipeline
  logic                     p1_v_q, p2_v_q, p1_z_q;
  logic [SLOT_W-1:0]        p1_k_q, p2_k_q;
  logic signed [2*ELEM_W-1:0] prod_q;

  // square root and divider
  logic [SQV_W-1:0]         sq_v_q, sq_r_q, sq_bit_q;
  logic [ITER_W-1:0]        n_q;
  logic [DEN_W-1:0]         den_q;
  logic [DOT_W-1:0]         mag_q;
  logic                     neg_q, zero_q;
  logic [NUM_W-1:0]         num_q, dv_q;
  logic [Q_W-1:0]           qt_q;

  // best entry and pending result
  logic signed [ELEM_W-1:0] best_q;
  logic                     found_q;
  logic [LABEL_W-1:0]       bestlab_q;
  logic [LABEL_W-1:0]       r_lab_q;
  logic                     r_mat_q;
  logic signed [ELEM_W-1:0] r_sim_q;
  logic [STATUS_W-1:0]      r_st_q;

  // output register
  logic                     out_valid_q;
  logic [LABEL_W-1:0]       out_lab_q;
  logic                     out_mat_q;
  logic signed [ELEM_W-1:0] out_sim_q;
  logic [STATUS_W-1:0]      out_st_q;
  logic [ECNT_W-1:0]        out_cnt_q;

  // embedding memory
  logic signed [ELEM_W-1:0] embed_mem [STORE_DEPTH];
  logic signed [ELEM_W-1:0] rd_q;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;

  logic in_acc, is_forget, kind_n, eidx_live, room, mac_issue;
  logic fk_hit, dup_hit, en_ok, fg_do;
  logic [SLOT_W-1:0] fk, kidx, cidx, cm1;
  logic [SQV_W:0]    sq_t;
  logic signed [2*ELEM_W-1:0] esq;
  logic signed [ELEM_W-1:0]   s_cur;
  logic signed [Q_W:0]        nq;
  status_e en_st;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign is_forget   = (operation_i == OP_FORGET) || (operation_i == OP_FORGET_ALL);
  assign kind_n      = (eidx_q == '0) ? operation_i[0] : kind_q;
  assign eidx_live   = (eidx_q < IDX_W'(EMBED_DIM));
  assign room        = (count_q < CNT_W'(MAX_ENTRIES));
  assign kidx        = k_q[SLOT_W-1:0];
  assign cidx        = count_q[SLOT_W-1:0];
  assign cm1         = SLOT_W'(count_q - CNT_W'(1));
  assign esq         = element_i * element_i;
  assign mac_issue   = (state_q == S_MAC) && (k_q < count_q);

  // label search for forget and the duplicate check
  always_comb begin
    fk_hit  = 1'b0;
    fk      = '0;
    dup_hit = 1'b0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (i < int'(count_q) && lab_q[i] == label_i) begin
        fk_hit = 1'b1;
        fk     = SLOT_W'(i);
      end
      if (i < int'(count_q) && lab_q[i] == lab_in_q) dup_hit = 1'b1;
    end
  end

  assign fg_do = in_acc && (operation_i == OP_FORGET) && fk_hit;

  always_comb begin
    if (!gate_q) en_st = ST_GATE;
    else if (!room) en_st = ST_FULL;
    else if (dup_hit) en_st = ST_DUP;
    else en_st = ST_OK;
  end
  assign en_ok = (state_q == S_EFIN) && (en_st == ST_OK);

  // memory ports
  assign mem_we    = in_acc && !is_forget && kind_n && eidx_live && room;
  assign mem_waddr = ADDR_W'(map_q[cidx]) * ADDR_W'(EMBED_DIM) + ADDR_W'(eidx_q[EA_W-1:0]);
  assign mem_raddr = ADDR_W'(map_q[kidx]) * ADDR_W'(EMBED_DIM) + ADDR_W'(midx_q[EA_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (mem_we) embed_mem[mem_waddr] <= element_i;
    rd_q <= embed_mem[mem_raddr];
  end

  assign sq_t = {1'b0, sq_r_q} + {1'b0, sq_bit_q};

  // signed similarity from quotient and sign
  always_comb begin
    nq = -$signed({1'b0, qt_q});
    if (neg_q) begin
      s_cur = (nq < $signed((Q_W+1)'(SIM_MIN))) ? SIM_MIN : ELEM_W'(nq);
    end else begin
      s_cur = (qt_q > Q_W'(SIM_MAX)) ? SIM_MAX : ELEM_W'(qt_q);
    end
  end

  // per-entry payload, shifted on forget
  always_ff @(posedge clk_i) begin
    if (fg_do) begin
      for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
        if (i >= int'(fk) && i + 1 < int'(count_q)) begin
          lab_q[i] <= lab_q[i+1];
          sqn_q[i] <= sqn_q[i+1];
          len_q[i] <= len_q[i+1];
        end
      end
    end
    if (en_ok) begin
      lab_q[cidx] <= lab_in_q;
      sqn_q[cidx] <= sq_r_q[SQ_W-1:0];
      len_q[cidx] <= eidx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      thr_q       <= THR_RESET;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        map_q[i] <= SLOT_W'(i);
        dot_q[i] <= '0;
      end
      norm_q      <= '0;
      eidx_q      <= '0;
      kind_q      <= 1'b0;
      last_q      <= 1'b0;
      lab_in_q    <= '0;
      gate_q      <= 1'b0;
      elem_q      <= '0;
      midx_q      <= '0;
      k_q         <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p1_z_q      <= 1'b0;
      p1_k_q      <= '0;
      p2_k_q      <= '0;
      prod_q      <= '0;
      sq_v_q      <= '0;
      sq_r_q      <= '0;
      sq_bit_q    <= '0;
      n_q         <= '0;
      den_q       <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      zero_q      <= 1'b0;
      num_q       <= '0;
      dv_q        <= '0;
      qt_q        <= '0;
      best_q      <= SIM_MIN;
      found_q     <= 1'b0;
      bestlab_q   <= '0;
      r_lab_q     <= '0;
      r_mat_q     <= 1'b0;
      r_sim_q     <= '0;
      r_st_q      <= ST_OK;
      out_valid_q <= 1'b0;
      out_lab_q   <= '0;
      out_mat_q   <= 1'b0;
      out_sim_q   <= '0;
      out_st_q    <= ST_OK;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            r_lab_q <= '0;
            r_mat_q <= 1'b0;
            r_sim_q <= '0;
            r_st_q  <= ST_OK;
            if (is_forget) begin
              for (int i = 0; i < MAX_ENTRIES; i++) dot_q[i] <= '0;
              norm_q <= '0;
              eidx_q <= '0;
              kind_q <= 1'b0;
              if (operation_i == OP_FORGET_ALL) begin
                count_q <= '0;
              end else if (fk_hit) begin
                for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                  if (i >= int'(fk) && i + 1 < int'(count_q)) map_q[i] <= map_q[i+1];
                end
                map_q[cm1] <= map_q[fk];
                count_q    <= count_q - CNT_W'(1);
              end else begin
                r_st_q <= ST_NOT_FOUND;
              end
              state_q <= S_OUT;
            end else begin
              kind_q   <= kind_n;
              last_q   <= last_i;
              lab_in_q <= label_i;
              gate_q   <= gate_ok_i;
              elem_q   <= element_i;
              midx_q   <= eidx_q;
              k_q      <= '0;
              if (eidx_live) begin
                norm_q <= norm_q + NORM_W'(unsigned'(esq));
                eidx_q <= eidx_q + IDX_W'(1);
              end
              if (eidx_live && !kind_n) state_q <= S_MAC;
              else if (last_i) state_q <= S_SQI;
            end
          end
        end

        S_MAC: begin
          // issue read, multiply, accumulate
          p1_v_q <= mac_issue;
          p1_k_q <= kidx;
          p1_z_q <= (midx_q >= len_q[kidx]);
          if (mac_issue) k_q <= k_q + CNT_W'(1);
          p2_v_q <= p1_v_q;
          p2_k_q <= p1_k_q;
          prod_q <= elem_q * (p1_z_q ? $signed(ELEM_W'(0)) : rd_q);
          if (p2_v_q) dot_q[p2_k_q] <= dot_q[p2_k_q] + DOT_W'(prod_q);
          if (!mac_issue && !p1_v_q && !p2_v_q) state_q <= last_q ? S_SQI : S_IDLE;
        end

        S_SQI: begin
          sq_v_q   <= SQV_W'(norm_q);
          sq_r_q   <= '0;
          sq_bit_q <= SQV_W'(1) << (SQV_W - 2);
          n_q      <= '0;
          state_q  <= S_SQRT;
        end

        S_SQRT: begin
          if ({1'b0, sq_v_q} >= sq_t) begin
            sq_v_q <= sq_v_q - sq_t[SQV_W-1:0];
            sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
          end else begin
            sq_r_q <= sq_r_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          n_q      <= n_q + ITER_W'(1);
          if (n_q == ITER_W'(SQ_W - 1)) begin
            best_q  <= SIM_MIN;
            found_q <= 1'b0;
            k_q     <= '0;
            if (kind_q) state_q <= S_EFIN;
            else if (count_q == '0) state_q <= S_PFIN;
            else state_q <= S_DEN;
          end
        end

        S_EFIN: begin
          r_st_q <= en_st;
          if (en_st == ST_OK) count_q <= count_q + CNT_W'(1);
          for (int i = 0; i < MAX_ENTRIES; i++) dot_q[i] <= '0;
          norm_q  <= '0;
          eidx_q  <= '0;
          kind_q  <= 1'b0;
          state_q <= S_OUT;
        end

        S_DEN: begin
          den_q   <= DEN_W'(sq_r_q[SQ_W-1:0]) * DEN_W'(sqn_q[kidx]);
          neg_q   <= dot_q[kidx] < 0;
          mag_q   <= (dot_q[kidx] < 0) ? DOT_W'(-dot_q[kidx]) : DOT_W'(dot_q[kidx]);
          zero_q  <= (sq_r_q[SQ_W-1:0] == '0) || (sqn_q[kidx] == '0);
          state_q <= S_DIV0;
        end

        S_DIV0: begin
          num_q <= (NUM_W'(mag_q) << SCALE_SH) + NUM_W'(den_q);
          dv_q  <= NUM_W'(den_q) << Q_W;
          n_q   <= '0;
          if (zero_q) begin
            qt_q    <= '0;
            state_q <= S_CMP;
          end else if (((NUM_W'(mag_q) << SCALE_SH) + NUM_W'(den_q)) >=
                       (NUM_W'(den_q) << (Q_W + 1))) begin
            qt_q    <= Q_W'(1) << SCALE_SH;
            state_q <= S_CMP;
          end else begin
            qt_q    <= '0;
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          if (num_q >= dv_q) begin
            num_q <= num_q - dv_q;
            qt_q  <= {qt_q[Q_W-2:0], 1'b1};
          end else begin
            qt_q  <= {qt_q[Q_W-2:0], 1'b0};
          end
          dv_q <= dv_q >> 1;
          n_q  <= n_q + ITER_W'(1);
          if (n_q == ITER_W'(Q_W - 1)) state_q <= S_CMP;
        end

        S_CMP: begin
          // strictly greater keeps the earliest entry on ties
          if (s_cur > best_q) begin
            best_q    <= s_cur;
            found_q   <= 1'b1;
            bestlab_q <= lab_q[kidx];
          end
          k_q <= k_q + CNT_W'(1);
          if (k_q + CNT_W'(1) >= count_q) state_q <= S_PFIN;
          else state_q <= S_DEN;
        end

        S_PFIN: begin
          if (count_q != '0) begin
            r_sim_q <= best_q;
            if (found_q && best_q >= thr_q) begin
              r_mat_q <= 1'b1;
              r_lab_q <= bestlab_q;
            end
          end
          for (int i = 0; i < MAX_ENTRIES; i++) dot_q[i] <= '0;
          norm_q  <= '0;
          eidx_q  <= '0;
          kind_q  <= 1'b0;
          state_q <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_lab_q   <= r_lab_q;
            out_mat_q   <= r_mat_q;
            out_sim_q   <= r_sim_q;
            out_st_q    <= r_st_q;
            out_cnt_q   <= ECNT_W'(count_q);
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_label_o = out_lab_q;
  assign matched_o     = out_mat_q;
  assign similarity_o  = out_sim_q;
  assign status_o      = out_st_q;
  assign entry_count_o = out_cnt_q;

  `CMET_ASSERT_ALWAYS(a_count_max, !rst_ni || (count_q <= CNT_W'(MAX_ENTRIES)), "entry count above table size")
  `CMET_ASSERT(a_eidx_sat, eidx_q <= IDX_W'(EMBED_DIM), "element index past embedding length")
  `CMET_ASSERT(a_pipe_mac, p2_v_q |-> state_q == S_MAC, "multiply pipeline busy outside mac")
  `CMET_ASSERT(a_out_hold, (state_q == S_OUT) && out_valid_q && out_stall_i |=> state_q == S_OUT, "result overwrote a held word")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives enroll, probe and forget words into the cosine match enrollment
// table and checks every result against a cycle-free model of the table.
// Idles both channels at random and changes the match threshold between
// phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import cmet_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [LABEL_W-1:0]       label;
    logic                     matched;
    logic signed [ELEM_W-1:0] similarity;
    logic [STATUS_W-1:0]      status;
    logic [ECNT_W-1:0]        count;
  } verdict_t;

  // model of the table, its open stream and the queue of pending verdicts
  class match_scoreboard;
    logic signed [ELEM_W-1:0] vectors [MAX_ENTRIES][EMBED_DIM];
    logic [LABEL_W-1:0]       labels [MAX_ENTRIES];
    longint unsigned          norms [MAX_ENTRIES];
    longint                   dots [MAX_ENTRIES];
    longint unsigned          stream_norm;
    int                       count;
    int                       idx;
    bit                       enrolling;
    int                       threshold;
    verdict_t                 pending [$];
    int                       errors;

    function new();
      count = 0;
      threshold = THR_RESET;
      errors = 0;
      foreach (vectors[k, i]) vectors[k][i] = '0;
      drop_stream();
    endfunction

    function void drop_stream();
      foreach (dots[k]) dots[k] = 0;
      stream_norm = 0;
      idx = 0;
      enrolling = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function int cosine(longint dot, longint unsigned na, longint unsigned nb);
      longint unsigned den, mag;
      longint q;
      if (na == 0 || nb == 0) return 0;
      den = isqrt(na) * isqrt(nb);
      mag = (dot < 0) ? longint'(-dot) : longint'(dot);
      mag = (mag * 65536 + den) / (2 * den);
      if (mag > 65536) mag = 65536;
      q = (dot < 0) ? -longint'(mag) : longint'(mag);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
    endfunction

    function void note_input(op_e op, logic signed [ELEM_W-1:0] elem, logic last,
                             logic [LABEL_W-1:0] label, logic gate);
      verdict_t v;
      int k, best, best_k, s;
      bit found, dup;
      v = '{label: '0, matched: 1'b0, similarity: '0, status: ST_OK, count: '0};
      if (op == OP_FORGET || op == OP_FORGET_ALL) begin
        drop_stream();
        if (op == OP_FORGET_ALL) begin
          count = 0;
        end else begin
          for (k = 0; k < count && labels[k] != label; k++) ;
          if (k >= count) begin
            v.status = ST_NOT_FOUND;
          end else begin
            for (; k + 1 < count; k++) begin
              labels[k] = labels[k+1];
              norms[k] = norms[k+1];
              vectors[k] = vectors[k+1];
            end
            count--;
          end
        end
      end else begin
        if (idx == 0) enrolling = (op == OP_ENROLL);
        if (idx < EMBED_DIM) begin
          if (!enrolling) begin
            for (k = 0; k < count; k++) dots[k] += longint'(elem) * longint'(vectors[k][idx]);
          end else if (count < MAX_ENTRIES) begin
            vectors[count][idx] = elem;
          end
          stream_norm += longint'(elem) * longint'(elem);
          idx++;
        end
        if (!last) return;
        if (!enrolling) begin
          if (count > 0) begin
            best = -32768;
            best_k = 0;
            found = 0;
            for (k = 0; k < count; k++) begin
              s = cosine(dots[k], stream_norm, norms[k]);
              if (s > best) begin
                best = s;
                best_k = k;
                found = 1;
              end
            end
            v.similarity = best[ELEM_W-1:0];
            if (found && best >= threshold) begin
              v.matched = 1'b1;
              v.label = labels[best_k];
            end
          end
        end else begin
          dup = 0;
          for (k = 0; k < count; k++) if (labels[k] == label) dup = 1;
          if (!gate) v.status = ST_GATE;
          else if (count >= MAX_ENTRIES) v.status = ST_FULL;
          else if (dup) v.status = ST_DUP;
          else begin
            for (k = idx; k < EMBED_DIM; k++) vectors[count][k] = '0;
            labels[count] = label;
            norms[count] = stream_norm;
            count++;
          end
        end
        drop_stream();
      end
      v.count = count[ECNT_W-1:0];
      pending = {pending, v};
    endfunction

    function void check_result(verdict_t got);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word, label %0d status %0d", got.label, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.label !== e.label) begin
        $error("match_label: expected %0d, got %0d", e.label, got.label);
        errors++;
      end
      if (got.matched !== e.matched) begin
        $error("matched: expected %0d, got %0d", e.matched, got.matched);
        errors++;
      end
      if (got.similarity !== e.similarity) begin
        $error("similarity: expected %0d, got %0d", e.similarity, got.similarity);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.count !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               operation = '0;
  logic signed [ELEM_W-1:0] element = '0;
  logic                     last = 1'b0;
  logic [LABEL_W-1:0]       label = '0;
  logic                     gate_ok = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [LABEL_W-1:0]       match_label;
  logic                     matched;
  logic signed [ELEM_W-1:0] similarity;
  logic [STATUS_W-1:0]      status;
  logic [ECNT_W-1:0]        entry_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic signed [ELEM_W-1:0] cfg_data = '0;

  match_scoreboard sb = new();
  bit calm = 0;
  int cycles = 0;

  cosine_match_enrollment_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .element_i     (element),
    .last_i        (last),
    .label_i       (label),
    .gate_ok_i     (gate_ok),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .match_label_o (match_label),
    .matched_o     (matched),
    .similarity_o  (similarity),
    .status_o      (status),
    .entry_count_o (entry_count),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: each accepted word is followed by a random stall
  initial begin : result_side
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        sb.check_result('{label: match_label, matched: matched, similarity: similarity,
                          status: status, count: entry_count});
        hold = calm ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(op_e op, logic signed [ELEM_W-1:0] elem, logic lst,
                      logic [LABEL_W-1:0] lbl, logic gate);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    operation <= op;
    element <= elem;
    last <= lst;
    label <= lbl;
    gate_ok <= gate;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(op, elem, lst, lbl, gate);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return SIM_MAX;
      1: return SIM_MIN;
      2: return '0;
      3: return ELEM_W'($signed($urandom_range(0, 200)) - 100);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    return ($urandom_range(0, 3) == 0) ? LABEL_W'($urandom) : LABEL_W'($urandom_range(0, 15));
  endfunction

  // one embedding stream; mixed marks later words with a random operation
  task automatic stream(op_e kind, int len, logic [LABEL_W-1:0] lbl, logic gate, bit mixed);
    op_e op;
    for (int i = 0; i < len; i++) begin
      op = (i > 0 && mixed) ? op_e'($urandom_range(0, 1)) : kind;
      if (i == len - 1) send(op, pick_elem(), 1'b1, lbl, gate);
      else send(op, pick_elem(), 1'b0, pick_label(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic signed [ELEM_W-1:0] thr);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.threshold = thr;
  endtask

  initial begin : stimulus
    int n, r, len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send(OP_PROBE, SIM_MAX, 1'b1, '0, 1'b0);            // probe of an empty table
    send(OP_ENROLL, SIM_MAX, 1'b1, 8'd5, 1'b1);
    send(OP_ENROLL, SIM_MIN, 1'b0, 8'd0, 1'b0);
    send(OP_PROBE, 16'sd7, 1'b1, 8'hff, 1'b1);          // later word kind ignored
    send(OP_ENROLL, 16'sd3, 1'b1, 8'd9, 1'b0);          // gate refused
    send(OP_ENROLL, 16'sd3, 1'b1, 8'd5, 1'b1);          // duplicate label
    send(OP_PROBE, '0, 1'b1, '0, 1'b0);                 // zero norm probe
    send(OP_PROBE, SIM_MAX, 1'b1, '0, 1'b0);
    send(OP_PROBE, SIM_MIN, 1'b0, '0, 1'b0);
    send(OP_FORGET, '0, 1'b0, 8'd99, 1'b0);             // abort stream, not found
    send(OP_FORGET, '0, 1'b0, 8'd5, 1'b0);
    for (int i = 0; i < 9; i++)
      send(OP_ENROLL, ELEM_W'(1000 * (i + 1)), 1'b1, LABEL_W'(100 + i), 1'b1);
    send(OP_ENROLL, 16'sd1, 1'b1, 8'd200, 1'b1);        // table full
    send(OP_PROBE, 16'sd50, 1'b0, '0, 1'b0);
    send(OP_FORGET_ALL, '0, 1'b1, '0, 1'b0);
    send(OP_ENROLL, 16'sd20000, 1'b1, 8'd1, 1'b1);
    set_threshold(SIM_MIN);
    send(OP_PROBE, -16'sd20000, 1'b1, '0, 1'b0);        // nothing above minus one
    send(OP_PROBE, 16'sd20000, 1'b1, '0, 1'b0);

    // random phases, each under its own threshold
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_threshold(SIM_MAX);
        1: set_threshold('0);
        2: set_threshold(ELEM_W'($urandom));
        3: set_threshold(SIM_MIN);
        default: set_threshold(THR_RESET);
      endcase
      n = 0;
      while (n < 340) begin
        if ($urandom_range(0, 7) == 0) calm = !calm;
        r = $urandom_range(0, 99);
        len = $urandom_range(1, 8);
        if ($urandom_range(0, 150) == 0) len = (r & 1) ? EMBED_DIM : EMBED_DIM + 3;
        if (r < 40) begin
          stream(OP_ENROLL, len, pick_label(), $urandom_range(0, 9) != 0,
                 $urandom_range(0, 9) == 0);
          n += len;
        end else if (r < 80) begin
          stream(OP_PROBE, len, pick_label(), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 9) == 0);
          n += len;
        end else if (r < 90) begin
          if (sb.count > 0 && $urandom_range(0, 3) != 0)
            send(OP_FORGET, pick_elem(), 1'($urandom_range(0, 1)),
                 sb.labels[$urandom_range(0, sb.count - 1)], 1'($urandom_range(0, 1)));
          else
            send(OP_FORGET, pick_elem(), 1'($urandom_range(0, 1)), pick_label(), 1'b1);
          n++;
        end else if (r < 94) begin
          send(OP_FORGET_ALL, pick_elem(), 1'($urandom_range(0, 1)), pick_label(), 1'b1);
          n++;
        end else begin
          // broken stream cut short by a forget
          stream(op_e'($urandom_range(0, 1)), len + 1, pick_label(), 1'b1, 1'b0);
          send(OP_PROBE, pick_elem(), 1'b0, '0, 1'b0);
          send(op_e'($urandom_range(2, 3)), '0, 1'b0, pick_label(), 1'b0);
          n += len + 3;
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
